>>> sv/mfd_pkg.sv
// Package for the median fire detector: field widths, register indexes,
// reset values, the queue item type and the back-end sequencer states.
// No dependencies.
package mfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int NEED_W    = 5;
  localparam int HSEEN_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COUNT_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD    = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD_RST    = 16'sd58;
  localparam logic [NEED_W-1:0]          HIGH_COUNT_NEEDED_RST = 5'd27;
  localparam logic [SAMPLE_W-1:0]        RISE_THRESHOLD_RST    = 16'd8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] med;
    logic                       full;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] high_thr;
    logic [NEED_W-1:0]          need;
    logic [SAMPLE_W-1:0]        rise_thr;
    logic                       thr_wr;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SWEEP,
    B_RDOLD,
    B_PUSH,
    B_CHECK,
    B_EMIT
  } back_state_t;

endpackage

>>> sv/mfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mfd_queue.sv
// Two-entry item queue between the front and back ends.
// Depends on mfd_pkg for the item type.
module mfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mfd_pkg::item_t push_item,
  output logic          push_ready,
  input  logic          pop,
  output mfd_pkg::item_t head_item,
  output logic          head_valid
);

  mfd_pkg::item_t ent_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && push_ready) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop && head_valid) begin
      rptr_nxt = ~rptr_r;
    end
    case ({push && push_ready, pop && head_valid})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      ent_r[wptr_r] <= push_item;
    end
  end

endmodule

>>> sv/mfd_front.sv
// Front end: takes samples into the raw window and ranks them to a median.
// Depends on mfd_pkg for widths and the item type.
module mfd_front #(
  parameter int TAPS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              q_push,
  output mfd_pkg::item_t                    q_item,
  input  logic                              q_ready
);

  localparam int FW  = $clog2(TAPS + 1);
  localparam int RW  = $clog2(TAPS);
  localparam int MID = (TAPS - 1) / 2;

  logic signed [mfd_pkg::SAMPLE_W-1:0] win_r [TAPS];
  logic [FW-1:0]                       fill_r, fill_nxt;
  logic                                pend_r, pend_nxt;
  logic                                accept;
  logic signed [mfd_pkg::SAMPLE_W-1:0] med;

  assign in_ready = !pend_r || q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = pend_r && q_ready;

  always_comb begin
    logic [RW-1:0] rank;
    med  = '0;
    rank = '0;
    for (int i = 0; i < TAPS; i++) begin
      rank = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (j != i) begin
          if (win_r[j] < win_r[i] || (j < i && win_r[j] == win_r[i])) begin
            rank = rank + 1'b1;
          end
        end
      end
      if (rank == RW'(MID)) begin
        med = win_r[i];
      end
    end
  end

  assign q_item.med  = med;
  assign q_item.full = (fill_r == FW'(TAPS));

  always_comb begin
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    if (q_push) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt = 1'b1;
      if (fill_r != FW'(TAPS)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_sample;
      for (int i = 1; i < TAPS; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

endmodule

>>> sv/mfd_back.sv
// Back end: median history in RAM, high count, alarm latch and result register.
// Depends on mfd_pkg and mfd_ram.
module mfd_back #(
  parameter int DEPTH = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mfd_pkg::cfg_t                      cfg,
  input  logic                               q_valid,
  input  mfd_pkg::item_t                     q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mfd_pkg::SAMPLE_W-1:0] out_median_value,
  output logic                               out_median_valid,
  output logic [mfd_pkg::HSEEN_W-1:0]        out_high_seen,
  output logic                               out_alarm
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = $clog2(DEPTH);
  localparam int KW = (CW > mfd_pkg::NEED_W) ? CW : mfd_pkg::NEED_W;
  localparam int SW = mfd_pkg::SAMPLE_W;

  mfd_pkg::back_state_t state_r, state_nxt;

  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sidx_r, sidx_nxt;
  logic          sv_r, sv_nxt;
  logic          alarm_r, alarm_nxt;
  logic          stale_r, stale_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_med_r, out_med_nxt;
  logic                 out_mv_r, out_mv_nxt;
  logic [mfd_pkg::HSEEN_W-1:0] out_hs_r, out_hs_nxt;
  logic                 out_al_r, out_al_nxt;

  logic          ram_we;
  logic [HW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  logic                 full_now;
  logic signed [SW-1:0] rd_s;
  logic signed [SW:0]   diff;
  logic [KW-1:0]        cnt_k;
  logic [mfd_pkg::HSEEN_W-1:0] hs_sat;
  logic                 ev_hi, new_hi, highs_ok, rise_ok;

  mfd_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full_now = (fill_r == CW'(DEPTH));
  assign rd_s     = $signed(ram_rdata);
  assign diff     = {q_item.med[SW-1], q_item.med} - {rd_s[SW-1], rd_s};
  assign cnt_k    = KW'(count_r);
  assign hs_sat   = (cnt_k > KW'(31)) ? 5'd31 : cnt_k[mfd_pkg::HSEEN_W-1:0];
  assign ev_hi    = full_now && (rd_s >= cfg.high_thr);
  assign new_hi   = ($signed(q_item.med) >= cfg.high_thr);
  assign highs_ok = (cnt_k >= KW'(cfg.need));
  assign rise_ok  = !diff[SW] && (diff[SW-1:0] >= cfg.rise_thr);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    sidx_nxt      = sidx_r;
    sv_nxt        = sv_r;
    alarm_nxt     = alarm_r;
    stale_nxt     = stale_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_med_nxt   = out_med_r;
    out_mv_nxt    = out_mv_r;
    out_hs_nxt    = out_hs_r;
    out_al_nxt    = out_al_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = q_item.med;
    ram_raddr     = head_r;

    unique case (state_r)
      mfd_pkg::B_IDLE: begin
        if (stale_r) begin
          count_nxt = '0;
          sidx_nxt  = '0;
          sv_nxt    = 1'b0;
          state_nxt = mfd_pkg::B_SWEEP;
        end else if (q_valid) begin
          state_nxt = q_item.full ? mfd_pkg::B_RDOLD : mfd_pkg::B_EMIT;
        end
      end
      mfd_pkg::B_SWEEP: begin
        ram_raddr = sidx_r[HW-1:0];
        if (sidx_r != fill_r) begin
          sidx_nxt = sidx_r + 1'b1;
          sv_nxt   = 1'b1;
        end else begin
          sv_nxt = 1'b0;
        end
        if (sv_r && rd_s >= cfg.high_thr) begin
          count_nxt = count_r + 1'b1;
        end
        if (cfg.thr_wr) begin
          state_nxt = mfd_pkg::B_IDLE;
        end else if (sidx_r == fill_r && !sv_r) begin
          stale_nxt = 1'b0;
          state_nxt = mfd_pkg::B_IDLE;
        end
      end
      mfd_pkg::B_RDOLD: begin
        state_nxt = mfd_pkg::B_PUSH;
      end
      mfd_pkg::B_PUSH: begin
        ram_we    = 1'b1;
        count_nxt = count_r - CW'(ev_hi) + CW'(new_hi);
        head_nxt  = (head_r == HW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_nxt  = full_now ? fill_r : fill_r + 1'b1;
        ram_raddr = head_nxt;
        state_nxt = (full_now || fill_r == CW'(DEPTH - 1)) ? mfd_pkg::B_CHECK
                                                           : mfd_pkg::B_EMIT;
      end
      mfd_pkg::B_CHECK: begin
        if (highs_ok || rise_ok) begin
          alarm_nxt = 1'b1;
        end
        state_nxt = mfd_pkg::B_EMIT;
      end
      mfd_pkg::B_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = q_item.full ? q_item.med : '0;
          out_mv_nxt    = q_item.full;
          out_hs_nxt    = hs_sat;
          out_al_nxt    = alarm_r;
          q_pop         = 1'b1;
          state_nxt     = mfd_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = mfd_pkg::B_IDLE;
      end
    endcase

    if (cfg.thr_wr) begin
      stale_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfd_pkg::B_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      sidx_r      <= '0;
      sv_r        <= 1'b0;
      alarm_r     <= 1'b0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      sidx_r      <= sidx_nxt;
      sv_r        <= sv_nxt;
      alarm_r     <= alarm_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_med_r <= out_med_nxt;
    out_mv_r  <= out_mv_nxt;
    out_hs_r  <= out_hs_nxt;
    out_al_r  <= out_al_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;
  assign out_median_valid = out_mv_r;
  assign out_high_seen    = out_hs_r;
  assign out_alarm        = out_al_r;

  a_alarm_holds: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |=> alarm_r)
    else $error("alarm latch dropped");

  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mfd_pkg::B_SWEEP) |-> (count_r <= fill_r))
    else $error("high count exceeds history fill");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("history fill overflow");

  a_check_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfd_pkg::B_CHECK) |-> full_now)
    else $error("alarm check with partial history");

endmodule

>>> sv/median_fire_detector.sv
// Median-of-N heat detector with fixed-level and rate-of-rise alarm.
// Depends on mfd_pkg, mfd_front, mfd_queue and mfd_back.
// Usage:
//   in_*   : one signed temperature sample per item (valid/ready).
//   out_*  : one result per item: median, median-valid flag, count of high
//            medians in the history (saturating at 31) and the alarm latch.
//   cfg_*  : register write port, one write per cycle with cfg_we high;
//            index 0 high threshold, 1 high count needed, 2 rise threshold.
// Sequencing:
//   The front end ranks the sample window in the cycle after acceptance and
//   hands the item to a two-entry queue. The back-end sequencer works on one
//   item at a time: before the window fills it only emits the result, while
//   the history fills it also reads and writes the history RAM, and once it
//   is full (history RAM read, write and oldest-entry read) it also checks
//   the alarm. The queue lets the front end take new samples meanwhile.
//   A high-threshold write triggers a recount over the history before the
//   next item is processed.
// Reset clears window and history fill, ring head, high count and alarm,
// and loads the registers with 58, 27 and 8; no clearing pass. A stalled
// receiver holds the result register; the queue then fills and in_ready drops.
module median_fire_detector #(
  parameter int MEDIAN_TAPS   = 5,
  parameter int HISTORY_DEPTH = 30
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mfd_pkg::SAMPLE_W-1:0]  out_median_value,
  output logic                                out_median_valid,
  output logic [mfd_pkg::HSEEN_W-1:0]         out_high_seen,
  output logic                                out_alarm,
  input  logic                                cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfd_pkg::SAMPLE_W-1:0]        cfg_wdata
);

  logic signed [mfd_pkg::SAMPLE_W-1:0] high_thr_r, high_thr_nxt;
  logic [mfd_pkg::NEED_W-1:0]          need_r, need_nxt;
  logic [mfd_pkg::SAMPLE_W-1:0]        rise_thr_r, rise_thr_nxt;
  logic                                thr_wr;

  mfd_pkg::cfg_t  cfg;
  mfd_pkg::item_t f_item, q_head;
  logic           f_push, q_ready, q_valid, q_pop;

  always_comb begin
    high_thr_nxt = high_thr_r;
    need_nxt     = need_r;
    rise_thr_nxt = rise_thr_r;
    thr_wr       = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        mfd_pkg::REG_HIGH_THRESHOLD: begin
          high_thr_nxt = $signed(cfg_wdata);
          thr_wr       = 1'b1;
        end
        mfd_pkg::REG_HIGH_COUNT_NEEDED: begin
          need_nxt = cfg_wdata[mfd_pkg::NEED_W-1:0];
        end
        mfd_pkg::REG_RISE_THRESHOLD: begin
          rise_thr_nxt = cfg_wdata;
        end
        default: begin
          high_thr_nxt = high_thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= mfd_pkg::HIGH_THRESHOLD_RST;
      need_r     <= mfd_pkg::HIGH_COUNT_NEEDED_RST;
      rise_thr_r <= mfd_pkg::RISE_THRESHOLD_RST;
    end else begin
      high_thr_r <= high_thr_nxt;
      need_r     <= need_nxt;
      rise_thr_r <= rise_thr_nxt;
    end
  end

  assign cfg.high_thr = high_thr_r;
  assign cfg.need     = need_r;
  assign cfg.rise_thr = rise_thr_r;
  assign cfg.thr_wr   = thr_wr;

  mfd_front #(.TAPS(MEDIAN_TAPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_push    (f_push),
    .q_item    (f_item),
    .q_ready   (q_ready)
  );

  mfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_item  (f_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_item  (q_head),
    .head_valid (q_valid)
  );

  mfd_back #(.DEPTH(HISTORY_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median_value (out_median_value),
    .out_median_valid (out_median_valid),
    .out_high_seen    (out_high_seen),
    .out_alarm        (out_alarm)
  );

endmodule
